// File: design/bba_pkg.sv
package bba_pkg;
   localparam int MIN_ORDER    = 5;
   localparam int MAX_ORDER    = 16;
   localparam int HEADER_BYTES = 24;
   localparam int GRAN_BITS    = MAX_ORDER - MIN_ORDER;
   localparam int GRANULES     = 1 << GRAN_BITS;
   localparam int LINK_BITS    = GRAN_BITS + 1;
   localparam int ORD_BITS     = 5;
   localparam int NUM_ORDERS   = MAX_ORDER + 1;
   // granule header: free flag and block order
   localparam int HDR_BITS     = 1 + ORD_BITS;

   localparam logic [1:0] STATUS_OK  = 2'd0;
   localparam logic [1:0] STATUS_OOM = 2'd1;
   localparam logic [1:0] STATUS_DBL = 2'd2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [0:0] CSR_POOL_BASE  = 1'b0;
   localparam logic [0:0] CSR_POOL_ORDER = 1'b1;

   localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(GRANULES);

   typedef struct packed {
      logic                is_free;
      logic [ORD_BITS-1:0] order;
   } hdr_type;
endpackage

// File: design/bba_ram.sv
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: design/buddy_block_allocator.sv
// Binary buddy allocator over a pool of 2^pool_order bytes starting at pool_base,
// tracked in 32-byte granules, with a 24-byte header in front of every payload.
// Issue a transaction by raising start while busy is low; it is taken at that edge
// and busy stays high until the result. Exactly one result appears for one cycle
// with rsp_valid high and must be captured then, since the receiver cannot stall
// it. busy is already low in that cycle, so the next transaction can be taken at
// the edge that ends it. A small sequencer walks one order per step over the
// granule table (registered read); the pool order defaults to 16 (64 KiB). An
// allocation steps up to the smallest fitting order k, scans upward for a free
// block of order j, splits it down one order at a time to k and takes the head
// of list k; a request that cannot be met answers with out of memory. A free is
// refused when the address or header does not fit; otherwise it merges with
// free buddies until one is busy or the pool order is reached, then appends the
// block to the tail of its list.
// After reset and after any csr write the granule table (2048 entries) is
// cleared one entry a cycle with busy held high; csr writes restart the sweep
// and drop every allocation.
module buddy_block_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [16:0] req_request_size,
   input  logic [31:0] req_block_address,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_address,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import bba_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE,
      S_A_SIZE, S_A_SCAN,
      S_SP_RD, S_SP_WT, S_SP_HI,
      S_TK_RD, S_TK_WT,
      S_F_RD, S_F_WT, S_B_RD, S_B_WT,
      S_F_APP, S_F_APP2, S_DONE
   } state_type;

   state_type state_ff;
   logic [31:0]          base_ff;
   logic [ORD_BITS-1:0]  porder_ff;
   logic [GRAN_BITS:0]   clr_ff;
   logic [16:0]          size_ff;
   logic [31:0]          addr_ff;
   logic [ORD_BITS-1:0]  k_ff;    // target / current order
   logic [ORD_BITS-1:0]  j_ff;    // scan / split order
   logic [GRAN_BITS-1:0] g_ff;    // block being worked on
   logic [GRAN_BITS-1:0] b_ff;    // buddy
   logic [LINK_BITS-1:0] head_ff [NUM_ORDERS];
   logic [LINK_BITS-1:0] tail_ff [NUM_ORDERS];
   logic [31:0]          res_ff;
   logic [1:0]           st_ff;
   logic                 valid_ff;

   // granule table split by field: header, next link, prev link.
   // One shared read address; data returns the next cycle.
   logic                 hdr_we, nxt_we, prv_we;
   logic [GRAN_BITS-1:0] raddr, hdr_wa, nxt_wa, prv_wa;
   hdr_type              hdr_wd, hdr_rd;
   logic [LINK_BITS-1:0] nxt_wd, nxt_rd, prv_wd, prv_rd;

   bba_ram #(.WIDTH(HDR_BITS), .DEPTH(GRANULES)) u_hdr (
      .clock(clock), .wr_en(hdr_we), .wr_addr(hdr_wa), .wr_data(hdr_wd),
      .rd_addr(raddr), .rd_data(hdr_rd)
   );

   bba_ram #(.WIDTH(LINK_BITS), .DEPTH(GRANULES)) u_next (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(raddr), .rd_data(nxt_rd)
   );

   bba_ram #(.WIDTH(LINK_BITS), .DEPTH(GRANULES)) u_prev (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_addr(raddr), .rd_data(prv_rd)
   );

   logic [ORD_BITS-1:0] eff;
   always_comb begin
      eff = porder_ff;
      if (porder_ff < ORD_BITS'(MIN_ORDER)) eff = ORD_BITS'(MIN_ORDER);
      if (porder_ff > ORD_BITS'(MAX_ORDER)) eff = ORD_BITS'(MAX_ORDER);
   end

   function automatic logic [GRAN_BITS-1:0] ostep(input logic [ORD_BITS-1:0] o);
      return GRAN_BITS'(1) << (o - ORD_BITS'(MIN_ORDER));
   endfunction

   function automatic logic [GRAN_BITS-1:0] gof(input logic [LINK_BITS-1:0] l);
      return l[GRAN_BITS-1:0];
   endfunction

   // free item address decode
   logic [31:0]          off;
   logic [ORD_BITS-1:0]  rord;
   logic [GRAN_BITS:0]   omask;
   logic [GRAN_BITS-1:0] gfree;
   logic                 off_ok;
   logic                 bad_free;
   logic [GRAN_BITS-1:0] buddy;
   logic [ORD_BITS-1:0]  jm1;
   logic [GRAN_BITS-1:0] split_hi;
   logic [GRAN_BITS-1:0] merge_hi;
   logic                 merge_ok;
   logic [31:0]          alloc_addr;
   assign off      = addr_ff - base_ff - 32'(HEADER_BYTES);
   assign off_ok   = ((off >> eff) == 32'd0) && (off[MIN_ORDER-1:0] == '0);
   assign gfree    = off[MIN_ORDER +: GRAN_BITS];
   assign rord     = hdr_rd.order;
   assign omask    = (GRAN_BITS+1)'((GRAN_BITS+1)'(1) << (rord - ORD_BITS'(MIN_ORDER))) - 1'b1;
   assign bad_free = !off_ok || rord < ORD_BITS'(MIN_ORDER) || rord > eff ||
                     ((GRAN_BITS+1)'(g_ff) & omask) != '0 || hdr_rd.is_free;
   assign buddy    = g_ff ^ ostep(k_ff);
   assign jm1      = j_ff - 1'b1;
   assign split_hi = g_ff | ostep(jm1);
   assign merge_hi = (b_ff > g_ff) ? b_ff : g_ff;
   assign merge_ok = (hdr_rd.order == k_ff) && hdr_rd.is_free;
   assign alloc_addr = base_ff + 32'({g_ff, {MIN_ORDER{1'b0}}}) + 32'(HEADER_BYTES);

   logic [17:0] blk_room;
   assign blk_room = 18'((18'd1 << k_ff)) - 18'(HEADER_BYTES);

   always_comb begin
      raddr  = g_ff;
      hdr_we = 1'b0; hdr_wa = g_ff; hdr_wd = '{is_free: 1'b0, order: '0};
      nxt_we = 1'b0; nxt_wa = g_ff; nxt_wd = NIL;
      prv_we = 1'b0; prv_wa = g_ff; prv_wd = NIL;
      case (state_ff)
         S_CLEAR: begin
            hdr_we = 1'b1; hdr_wa = clr_ff[GRAN_BITS-1:0];
            hdr_wd = '{is_free: (clr_ff == '0), order: (clr_ff == '0) ? eff : '0};
            nxt_we = 1'b1; nxt_wa = clr_ff[GRAN_BITS-1:0];
            prv_we = 1'b1; prv_wa = clr_ff[GRAN_BITS-1:0];
         end
         S_SP_RD: raddr = gof(head_ff[j_ff]);
         S_TK_RD: raddr = gof(head_ff[k_ff]);
         // head leaves list j; lower half becomes head of list j-1
         S_SP_WT: begin
            if (nxt_rd != NIL) begin
               prv_we = 1'b1; prv_wa = gof(nxt_rd);
            end
            hdr_we = 1'b1; hdr_wd = '{is_free: 1'b1, order: jm1};
            nxt_we = 1'b1; nxt_wd = {1'b0, split_hi};
         end
         S_SP_HI: begin
            hdr_we = 1'b1; hdr_wa = split_hi; hdr_wd = '{is_free: 1'b1, order: jm1};
            nxt_we = 1'b1; nxt_wa = split_hi;
            prv_we = 1'b1; prv_wa = split_hi; prv_wd = {1'b0, g_ff};
         end
         S_TK_WT: begin
            if (nxt_rd != NIL) begin
               prv_we = 1'b1; prv_wa = gof(nxt_rd);
            end
            hdr_we = 1'b1; hdr_wd = '{is_free: 1'b0, order: k_ff};
         end
         S_F_RD: raddr = gfree;
         S_B_RD: raddr = buddy;
         // buddy unlink from anywhere in its list, upper header cleared
         S_B_WT: if (merge_ok) begin
            if (prv_rd != NIL) begin
               nxt_we = 1'b1; nxt_wa = gof(prv_rd); nxt_wd = nxt_rd;
            end
            if (nxt_rd != NIL) begin
               prv_we = 1'b1; prv_wa = gof(nxt_rd); prv_wd = prv_rd;
            end
            hdr_we = 1'b1; hdr_wa = merge_hi;
         end
         S_F_APP: begin
            hdr_we = 1'b1; hdr_wd = '{is_free: 1'b1, order: k_ff};
            prv_we = 1'b1; prv_wd = tail_ff[k_ff];
            if (tail_ff[k_ff] != NIL) begin
               nxt_we = 1'b1; nxt_wa = gof(tail_ff[k_ff]); nxt_wd = {1'b0, g_ff};
            end
         end
         S_F_APP2: nxt_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      valid_ff <= 1'b0;
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         base_ff   <= '0;
         porder_ff <= ORD_BITS'(MAX_ORDER);
         for (int i = 0; i < NUM_ORDERS; i++) begin
            head_ff[i] <= NIL; tail_ff[i] <= NIL;
         end
      end else if (csr_write_enable) begin
         if (csr_index == CSR_POOL_BASE) base_ff <= csr_write_data;
         else porder_ff <= csr_write_data[ORD_BITS-1:0];
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (GRAN_BITS+1)'(GRANULES - 1)) begin
                  for (int i = 0; i < NUM_ORDERS; i++) begin
                     head_ff[i] <= (ORD_BITS'(i) == eff) ? '0 : NIL;
                     tail_ff[i] <= (ORD_BITS'(i) == eff) ? '0 : NIL;
                  end
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: if (start) begin
               size_ff <= req_request_size;
               addr_ff <= req_block_address;
               k_ff <= ORD_BITS'(MIN_ORDER);
               state_ff <= (req_opcode == OP_ALLOC) ? S_A_SIZE : S_F_RD;
            end
            // one order per cycle: find k
            S_A_SIZE: begin
               if (k_ff > eff) begin
                  res_ff <= '0; st_ff <= STATUS_OOM; state_ff <= S_DONE;
               end else if (blk_room >= 18'(size_ff)) begin
                  j_ff <= k_ff; state_ff <= S_A_SCAN;
               end else k_ff <= k_ff + 1'b1;
            end
            S_A_SCAN: begin
               if (j_ff > eff) begin
                  res_ff <= '0; st_ff <= STATUS_OOM; state_ff <= S_DONE;
               end else if (head_ff[j_ff] != NIL) begin
                  state_ff <= (j_ff > k_ff) ? S_SP_RD : S_TK_RD;
               end else j_ff <= j_ff + 1'b1;
            end
            S_SP_RD: begin
               g_ff <= gof(head_ff[j_ff]); state_ff <= S_SP_WT;
            end
            // head unlink: head's prev is nil, so only next's prev changes
            S_SP_WT: begin
               head_ff[j_ff] <= nxt_rd;
               if (nxt_rd == NIL) tail_ff[j_ff] <= NIL;
               state_ff <= S_SP_HI;
            end
            S_SP_HI: begin
               // lower order list was empty (scan found none)
               head_ff[jm1] <= {1'b0, g_ff};
               tail_ff[jm1] <= {1'b0, split_hi};
               j_ff <= jm1;
               state_ff <= (jm1 > k_ff) ? S_SP_RD : S_TK_RD;
            end
            S_TK_RD: begin
               g_ff <= gof(head_ff[k_ff]); state_ff <= S_TK_WT;
            end
            S_TK_WT: begin
               head_ff[k_ff] <= nxt_rd;
               if (nxt_rd == NIL) tail_ff[k_ff] <= NIL;
               res_ff <= alloc_addr; st_ff <= STATUS_OK; state_ff <= S_DONE;
            end
            S_F_RD: begin
               g_ff <= gfree; state_ff <= S_F_WT;
            end
            S_F_WT: begin
               if (bad_free) begin
                  res_ff <= '0; st_ff <= STATUS_DBL; state_ff <= S_DONE;
               end else begin
                  k_ff <= rord; state_ff <= S_B_RD;
               end
            end
            S_B_RD: begin
               if (k_ff >= eff) state_ff <= S_F_APP;
               else begin b_ff <= buddy; state_ff <= S_B_WT; end
            end
            S_B_WT: begin
               if (!merge_ok) state_ff <= S_F_APP;
               else begin
                  if (prv_rd == NIL) head_ff[k_ff] <= nxt_rd;
                  if (nxt_rd == NIL) tail_ff[k_ff] <= prv_rd;
                  if (b_ff < g_ff) g_ff <= b_ff;
                  k_ff <= k_ff + 1'b1;
                  state_ff <= S_B_RD;
               end
            end
            S_F_APP: begin
               if (tail_ff[k_ff] == NIL) head_ff[k_ff] <= {1'b0, g_ff};
               tail_ff[k_ff] <= {1'b0, g_ff};
               state_ff <= S_F_APP2;
            end
            S_F_APP2: begin
               res_ff <= '0; st_ff <= STATUS_OK; state_ff <= S_DONE;
            end
            S_DONE: begin
               valid_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_CLEAR;
         endcase
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = valid_ff;
   assign rsp_result_address = res_ff;
   assign rsp_status         = st_ff;

`ifndef ASSERT_OFF
   a_oneshot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double result strobe");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(csr_write_enable)) |-> !busy) else $error("result while busy");
   a_ok_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> rsp_result_address == 32'd0)
      else $error("failure with address");
`endif
endmodule

// File: test/tb_top.sv
module tb_top;
   import bba_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_opcode = OP_ALLOC;
   logic [16:0] req_request_size = '0;
   logic [31:0] req_block_address = '0;
   logic        rsp_valid;
   logic [31:0] rsp_result_address;
   logic [1:0]  rsp_status;
   logic        csr_write_enable = 1'b0;
   logic [0:0]  csr_index = CSR_POOL_BASE;
   logic [31:0] csr_write_data = '0;

   buddy_block_allocator u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_request_size(req_request_size),
      .req_block_address(req_block_address), .rsp_valid(rsp_valid),
      .rsp_result_address(rsp_result_address), .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // predictor state: mirror of the granule table and the order lists
   localparam int LIMIT_CYCLES = 1500000;
   logic [31:0]          base_addr;
   logic [4:0]           order_reg;
   logic                 g_free [GRANULES];
   logic [4:0]           g_ord [GRANULES];
   int                   g_next [GRANULES];
   int                   g_prev [GRANULES];
   int                   list_head [NUM_ORDERS];
   int                   list_tail [NUM_ORDERS];

   typedef struct packed {
      logic [31:0] addr;
      logic [1:0]  status;
   } result_type;

   result_type    expected_q[$];
   logic [31:0]   live_addrs[$];   // addresses handed out and not yet freed
   int            error_count = 0;
   int            cycle_count = 0;
   int            sent_count = 0;
   int            got_count = 0;
   int            oom_count = 0;
   int            dbl_count = 0;
   bit            idle_on = 1'b1;

   function automatic int pool_ord();
      int p;
      p = order_reg;
      if (p < MIN_ORDER) p = MIN_ORDER;
      if (p > MAX_ORDER) p = MAX_ORDER;
      return p;
   endfunction

   function automatic void pool_clear();
      int p;
      p = pool_ord();
      for (int i = 0; i < GRANULES; i++) begin
         g_free[i] = 1'b0; g_ord[i] = '0;
         g_next[i] = GRANULES; g_prev[i] = GRANULES;
      end
      for (int i = 0; i < NUM_ORDERS; i++) begin
         list_head[i] = GRANULES; list_tail[i] = GRANULES;
      end
      g_free[0] = 1'b1;
      g_ord[0] = p[4:0];
      list_head[p] = 0;
      list_tail[p] = 0;
   endfunction

   function automatic void list_drop(int k, int g);
      int p, n;
      p = g_prev[g];
      n = g_next[g];
      if (p >= GRANULES) list_head[k] = n; else g_next[p] = n;
      if (n >= GRANULES) list_tail[k] = p; else g_prev[n] = p;
      g_prev[g] = GRANULES;
      g_next[g] = GRANULES;
   endfunction

   function automatic void list_push(int k, int g);
      int t;
      t = list_tail[k];
      g_prev[g] = t;
      g_next[g] = GRANULES;
      if (t >= GRANULES) list_head[k] = g; else g_next[t] = g;
      list_tail[k] = g;
   endfunction

   function automatic result_type predict_alloc(logic [16:0] size);
      result_type r;
      int p, k, j, lo, hi, g;
      r = '{addr: '0, status: STATUS_OOM};
      p = pool_ord();
      for (k = MIN_ORDER; k <= p; k++)
         if ((64'd1 << k) - HEADER_BYTES >= {47'd0, size}) break;
      if (k > p) return r;
      for (j = k; j <= p; j++)
         if (list_head[j] < GRANULES) break;
      if (j > p) return r;
      while (j > k) begin
         lo = list_head[j];
         hi = lo + (1 << (j - 1 - MIN_ORDER));
         list_drop(j, lo);
         j--;
         g_free[lo] = 1'b1; g_ord[lo] = j[4:0];
         g_free[hi] = 1'b1; g_ord[hi] = j[4:0];
         list_push(j, lo);
         list_push(j, hi);
      end
      g = list_head[k];
      list_drop(k, g);
      g_free[g] = 1'b0;
      r.addr = base_addr + 32'(g << MIN_ORDER) + 32'(HEADER_BYTES);
      r.status = STATUS_OK;
      return r;
   endfunction

   function automatic result_type predict_free(logic [31:0] addr);
      result_type r;
      logic [31:0] off;
      int p, g, k, b, hi;
      r = '{addr: '0, status: STATUS_DBL};
      p = pool_ord();
      off = addr - base_addr - 32'(HEADER_BYTES);
      if ({32'd0, off} >= (64'd1 << p)) return r;
      if (off[MIN_ORDER-1:0] != '0) return r;
      g = int'(off >> MIN_ORDER);
      k = g_ord[g];
      if (k < MIN_ORDER || k > p) return r;
      if ((g & ((1 << (k - MIN_ORDER)) - 1)) != 0) return r;
      if (g_free[g]) return r;
      while (k < p) begin
         b = g ^ (1 << (k - MIN_ORDER));
         if (g_ord[b] != k || !g_free[b]) break;
         list_drop(k, b);
         hi = (b > g) ? b : g;
         if (b < g) g = b;
         g_free[hi] = 1'b0;
         g_ord[hi] = '0;
         k++;
         g_ord[g] = k[4:0];
      end
      g_ord[g] = k[4:0];
      g_free[g] = 1'b1;
      list_push(k, g);
      r.status = STATUS_OK;
      return r;
   endfunction

   // result checker: every strobe must match the oldest expectation
   always @(posedge clock) begin
      result_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) begin
         got_count <= got_count + 1;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transaction result addr=%h status=%0d",
                     $time, rsp_result_address, rsp_status);
            error_count++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_result_address !== want.addr) begin
               $display("%0t: addr mismatch expected=%h actual=%h", $time,
                        want.addr, rsp_result_address);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch expected=%0d actual=%0d", $time,
                        want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // random idle gap on the sender side, taken now and then while idle_on is set
   task automatic sender_gap();
      if (idle_on && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 10)) @(negedge clock);
   endtask

   // issue one transaction; prediction runs when it is accepted
   task automatic send_op(logic op, logic [16:0] size, logic [31:0] addr);
      result_type r;
      sender_gap();
      req_opcode = op;
      req_request_size = size;
      req_block_address = addr;
      start = 1'b1;
      // busy only moves at rising edges, so a low value here means the next edge takes it
      while (busy) @(negedge clock);
      @(posedge clock);
      if (op == OP_ALLOC) begin
         r = predict_alloc(size);
         if (r.status == STATUS_OK) live_addrs.push_back(r.addr);
      end else begin
         r = predict_free(addr);
      end
      if (r.status == STATUS_OOM) oom_count++;
      if (r.status == STATUS_DBL) dbl_count++;
      expected_q.push_back(r);
      sent_count++;
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   // register write while idle; resets the pool to one free block
   task automatic write_csr(logic [0:0] idx, logic [31:0] data);
      drain();
      csr_index = idx;
      csr_write_data = data;
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == CSR_POOL_BASE) base_addr = data; else order_reg = data[4:0];
      pool_clear();
      live_addrs.delete();
   endtask

   task automatic free_live(int idx);
      logic [31:0] a;
      a = live_addrs[idx];
      live_addrs.delete(idx);
      send_op(OP_FREE, 17'($urandom), a);
   endtask

   // directed: extremes, oversize, double free, stray addresses, merging
   task automatic test_directed();
      send_op(OP_ALLOC, 17'd0, 32'hFFFF_FFFF);
      send_op(OP_ALLOC, 17'd8, '0);
      send_op(OP_ALLOC, 17'd9, '0);
      send_op(OP_ALLOC, 17'h1FFFF, '0);          // oversized
      send_op(OP_ALLOC, 17'd65536, '0);          // oversized
      send_op(OP_ALLOC, 17'd65512, '0);          // whole pool, pool is split: unmet
      send_op(OP_FREE, '0, 32'd24);
      send_op(OP_FREE, '0, 32'd24);              // double free
      send_op(OP_FREE, '0, 32'd25);              // off granule
      send_op(OP_FREE, '0, 32'hFFFF_FFFF);       // outside pool
      send_op(OP_FREE, '0, 32'd0);               // below header, wraps
      send_op(OP_FREE, '0, 32'd56);              // second block
      send_op(OP_FREE, '0, 32'd88);              // third block, merges back
      send_op(OP_FREE, '0, 32'd56);              // stale inside merged block
      send_op(OP_ALLOC, 17'd65512, '0);          // whole pool
      send_op(OP_ALLOC, 17'd1, '0);              // unmet
      send_op(OP_FREE, 17'h1FFFF, 32'd24);
      live_addrs.delete();
   endtask

   // config extremes: smallest pool, top base with wraparound, pool order clamping
   task automatic test_config();
      write_csr(CSR_POOL_ORDER, 32'd5);
      send_op(OP_ALLOC, 17'd8, '0);
      send_op(OP_ALLOC, 17'd0, '0);
      send_op(OP_FREE, '0, 32'd24);
      write_csr(CSR_POOL_BASE, 32'hFFFF_FFF0);
      send_op(OP_ALLOC, 17'd8, '0);
      send_op(OP_FREE, '0, 32'h0000_0008);
      write_csr(CSR_POOL_ORDER, 32'h1F);         // clamps to the largest order
      send_op(OP_ALLOC, 17'd65512, '0);
      write_csr(CSR_POOL_ORDER, 32'd0);          // clamps to the smallest order
      send_op(OP_ALLOC, 17'd9, '0);
      send_op(OP_ALLOC, 17'd8, '0);
   endtask

   // mostly well formed alloc/free traffic, some stray frees and odd sizes
   task automatic run_random(int n);
      int pick;
      logic [16:0] sz;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            case ($urandom_range(0, 3))
               0: sz = 17'($urandom_range(0, 40));
               1: sz = 17'($urandom_range(0, 500));
               2: sz = 17'($urandom_range(0, 4000));
               default: sz = 17'($urandom);
            endcase
            send_op(OP_ALLOC, sz, $urandom);
         end else if (pick < 88 && live_addrs.size() != 0) begin
            free_live($urandom_range(0, live_addrs.size() - 1));
         end else if (pick < 94) begin
            send_op(OP_FREE, 17'($urandom),
                    base_addr + 32'($urandom_range(0, 2047) << 5) + 32'd24);
         end else begin
            send_op(OP_FREE, 17'($urandom), $urandom);
         end
      end
   endtask

   initial begin
      base_addr = '0;
      order_reg = 5'd16;
      pool_clear();
      repeat (11) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_config();
      write_csr(CSR_POOL_BASE, 32'h8000_0000);
      write_csr(CSR_POOL_ORDER, 32'd16);
      run_random(800);
      write_csr(CSR_POOL_ORDER, 32'd9);          // tiny pool, frequent oom
      run_random(400);
      write_csr(CSR_POOL_BASE, $urandom);
      write_csr(CSR_POOL_ORDER, 32'd12);
      run_random(400);
      idle_on = 1'b0;                            // back to back tail
      run_random(400);
      drain();
      $display("ran %0d transactions, %0d results, %0d out of memory, %0d double free",
               sent_count, got_count, oom_count, dbl_count);
      $display("pool orders 5..16 with clamping, bases incl. wraparound");
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule
